### hdl/czre_pkg.sv
// czre_pkg: shared types, widths and codes of the column zero-run encoder
// no dependencies; imported by column_zero_run_encoder

package czre_pkg;

   // fixed field widths
   localparam int unsigned ELEM_W      = 64;
   localparam int unsigned CFG_W       = 11;
   localparam int unsigned COL_IDX_W   = 10;
   localparam int unsigned RUN_START_W = 10;
   localparam int unsigned RUN_END_W   = 11;
   localparam int unsigned NZ_CNT_W    = 11;
   localparam int unsigned RUN_CNT_W   = 10;
   localparam int unsigned CSR_IDX_W   = 1;

   // default size limits
   localparam int unsigned DEF_MAX_ROWS    = 1024;
   localparam int unsigned DEF_MAX_COLUMNS = 1024;

   // sign bit ignored: +0.0 and -0.0 both count as zero
   localparam logic [ELEM_W-1:0] ZERO_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic {
      KIND_VALUE = 1'b0,
      KIND_RUN   = 1'b1
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUM_ROWS    = 1'b0,
      REG_NUM_COLUMNS = 1'b1
   } reg_index_type;

   // first field in the lowest bits, so members are listed msb first
   typedef struct packed {
      logic                   matrix_done;
      logic                   column_done;
      logic [RUN_CNT_W-1:0]   zero_run_count;
      logic [NZ_CNT_W-1:0]    nonzero_count;
      logic [RUN_END_W-1:0]   run_end;
      logic [RUN_START_W-1:0] run_start;
      logic [ELEM_W-1:0]      nonzero_value;
      logic [COL_IDX_W-1:0]   column_index;
   } payload_type;

   localparam int unsigned PAYLOAD_W  = $bits(payload_type);
   localparam int unsigned RSP_DATA_W = ((PAYLOAD_W + 7) / 8) * 8;

   typedef struct packed {
      kind_type    kind;
      logic        last;
      payload_type payload;
   } result_type;

endpackage

### hdl/column_zero_run_encoder.sv
// column_zero_run_encoder: top level of the column-order zero-run encoder
// depends on czre_pkg for field widths, codes and the result struct

// Takes one 64-bit double pattern per beat on req_, in column order (rows 0 to
// num_rows-1 of column 0, then column 1, ...). Every nonzero element comes out
// on rsp_ as a value beat (tuser = 0) carrying the running nonzero count of its
// column; every maximal run of zeros comes out as one run beat (tuser = 1) with
// its first row and exclusive end row, sent when a nonzero element or the end
// of the column closes it. Both signed zeros count as zero. An element yields
// zero, one or two beats; rsp_tlast marks the last beat an element caused.
// Timing: an accepted element waits in the input register until the two-entry
// output queue has room for its beats, which are then loaded into the queue;
// q0 drives the port and q1 holds a second beat. One element is taken per
// cycle while the queue has room; the output port moves one beat per cycle
// while rsp_tready is high, so an element that closes a run ahead of a nonzero
// value gives two beats. The user writes num_rows and num_columns through csr_
// only while the stream is idle; the block does not enforce it. 0 acts as 1
// and values above MAX_ROWS / MAX_COLUMNS act as the maximum. After the last
// column the position wraps to row 0 of column 0. No clearing pass after reset.

module column_zero_run_encoder #(
   parameter int unsigned MAX_ROWS    = czre_pkg::DEF_MAX_ROWS,
   parameter int unsigned MAX_COLUMNS = czre_pkg::DEF_MAX_COLUMNS
) (
   input  logic                              clock,
   input  logic                              reset,
   // element input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [czre_pkg::ELEM_W-1:0]       req_tdata,   // element_bits
   // result output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // column_index, nonzero_value, run_start, run_end, nonzero_count,
   // zero_run_count, column_done, matrix_done, zero pad
   output logic [czre_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,   // kind
   output logic                              rsp_tlast,   // last beat of this element
   // register writes
   input  logic                              csr_we,
   input  logic [czre_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [czre_pkg::CFG_W-1:0]        csr_wdata
);
   import czre_pkg::*;

   // position widths follow the size limits
   localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int unsigned COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   // compare widths: hold the register value, the limit and position + 1
   localparam int unsigned RLIM_W = $clog2(MAX_ROWS + 1);
   localparam int unsigned CLIM_W = $clog2(MAX_COLUMNS + 1);
   localparam int unsigned RCMP_W = (RLIM_W > CFG_W) ? RLIM_W : CFG_W;
   localparam int unsigned CCMP_W = (CLIM_W > CFG_W) ? CLIM_W : CFG_W;
   localparam logic [RCMP_W-1:0] ROWS_LIMIT = RCMP_W'(MAX_ROWS);
   localparam logic [CCMP_W-1:0] COLS_LIMIT = CCMP_W'(MAX_COLUMNS);

   // configuration
   logic [CFG_W-1:0]      num_rows_ff, num_rows_in;
   logic [CFG_W-1:0]      num_cols_ff, num_cols_in;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [ELEM_W-1:0]     in_data_ff, in_data_in;

   // column scan state
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic                  in_run_ff, in_run_in;
   logic [ROW_W-1:0]      open_ff, open_in;
   logic [NZ_CNT_W-1:0]   nz_tally_ff, nz_tally_in;
   logic [RUN_CNT_W-1:0]  run_tally_ff, run_tally_in;

   // output queue: q0 drives the port, q1 holds a second beat
   result_type            q0_ff, q0_in;
   result_type            q1_ff, q1_in;
   logic [1:0]            cnt_ff, cnt_in;

   logic [RCMP_W-1:0]     rows_ext, rows_eff, row_next;
   logic [CCMP_W-1:0]     cols_ext, cols_eff, col_next;
   logic                  last_row, last_col, is_zero;
   logic [1:0]            n_res, space, kept;
   logic                  pop, advance;
   result_type            run_item, val_item, res0, res1, kept0;
   logic [NZ_CNT_W-1:0]   nz_inc;
   logic [RUN_CNT_W-1:0]  run_inc;

   // ---------------- size clamp and end-of-column tests ----------------
   always_comb begin
      rows_ext = RCMP_W'(num_rows_ff);
      cols_ext = CCMP_W'(num_cols_ff);
      if (num_rows_ff == '0) begin
         rows_eff = RCMP_W'(1);
      end else if (rows_ext > ROWS_LIMIT) begin
         rows_eff = ROWS_LIMIT;
      end else begin
         rows_eff = rows_ext;
      end
      if (num_cols_ff == '0) begin
         cols_eff = CCMP_W'(1);
      end else if (cols_ext > COLS_LIMIT) begin
         cols_eff = COLS_LIMIT;
      end else begin
         cols_eff = cols_ext;
      end
      row_next = RCMP_W'(row_ff) + RCMP_W'(1);
      col_next = CCMP_W'(col_ff) + CCMP_W'(1);
      // a position at or past the size (after a size change) closes at once
      last_row = (row_next >= rows_eff);
      last_col = (col_next >= cols_eff);
   end

   assign is_zero = ((in_data_ff & ZERO_MASK) == '0);
   assign nz_inc  = nz_tally_ff + NZ_CNT_W'(1);
   assign run_inc = run_tally_ff + RUN_CNT_W'(1);

   // ---------------- results of the registered element ----------------
   always_comb begin
      // run beat: closed by the last row (zero element) or by a nonzero element
      run_item                        = '0;
      run_item.kind                   = KIND_RUN;
      run_item.payload.column_index   = COL_IDX_W'(col_ff);
      run_item.payload.nonzero_count  = nz_tally_ff;
      run_item.payload.zero_run_count = run_inc;
      if (is_zero) begin
         run_item.last                   = 1'b1;
         run_item.payload.run_start      = in_run_ff ? RUN_START_W'(open_ff)
                                                     : RUN_START_W'(row_ff);
         run_item.payload.run_end        = RUN_END_W'(row_next);
         run_item.payload.column_done    = 1'b1;
         run_item.payload.matrix_done    = last_col;
      end else begin
         run_item.last                   = 1'b0;
         run_item.payload.run_start      = RUN_START_W'(open_ff);
         run_item.payload.run_end        = RUN_END_W'(row_ff);
         run_item.payload.column_done    = 1'b0;
         run_item.payload.matrix_done    = 1'b0;
      end

      // value beat
      val_item                        = '0;
      val_item.kind                   = KIND_VALUE;
      val_item.last                   = 1'b1;
      val_item.payload.column_index   = COL_IDX_W'(col_ff);
      val_item.payload.nonzero_value  = in_data_ff;
      val_item.payload.nonzero_count  = nz_inc;
      val_item.payload.zero_run_count = in_run_ff ? run_inc : run_tally_ff;
      val_item.payload.column_done    = last_row;
      val_item.payload.matrix_done    = last_row && last_col;

      // beat count: zero inside a column gives none
      if (is_zero) begin
         n_res = last_row ? 2'd1 : 2'd0;
      end else begin
         n_res = in_run_ff ? 2'd2 : 2'd1;
      end
      res0 = (is_zero || in_run_ff) ? run_item : val_item;
      res1 = val_item;
   end

   // ---------------- handshakes ----------------
   assign pop        = rsp_tvalid && rsp_tready;
   assign space      = 2'd2 - cnt_ff + {1'b0, pop};
   assign advance    = in_valid_ff && (n_res <= space);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = RSP_DATA_W'(q0_ff.payload);
   assign rsp_tuser  = q0_ff.kind;
   assign rsp_tlast  = q0_ff.last;

   // ---------------- next state ----------------
   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      in_data_in   = (req_tvalid && req_tready) ? req_tdata : in_data_ff;

      row_in       = row_ff;
      col_in       = col_ff;
      in_run_in    = in_run_ff;
      open_in      = open_ff;
      nz_tally_in  = nz_tally_ff;
      run_tally_in = run_tally_ff;

      if (advance) begin
         if (last_row) begin
            // column closes: counts and open run start over
            row_in       = '0;
            in_run_in    = 1'b0;
            open_in      = '0;
            nz_tally_in  = '0;
            run_tally_in = '0;
            col_in       = last_col ? '0 : COL_W'(col_next);
         end else begin
            row_in = ROW_W'(row_next);
            if (is_zero) begin
               if (!in_run_ff) begin
                  in_run_in = 1'b1;
                  open_in   = row_ff;
               end
            end else begin
               in_run_in    = 1'b0;
               nz_tally_in  = nz_inc;
               run_tally_in = in_run_ff ? run_inc : run_tally_ff;
            end
         end
      end

      // queue: drop the popped head, then append the new beats
      kept  = cnt_ff - {1'b0, pop};
      kept0 = pop ? q1_ff : q0_ff;
      q0_in = (kept != 2'd0) ? kept0 : res0;
      if (kept == 2'd2) begin
         q1_in = q1_ff;
      end else if (kept == 2'd1) begin
         q1_in = res0;
      end else begin
         q1_in = res1;
      end
      cnt_in = advance ? (kept + n_res) : kept;
   end

   // configuration writes
   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_NUM_ROWS: begin
               num_rows_in = csr_wdata;
            end
            REG_NUM_COLUMNS: begin
               num_cols_in = csr_wdata;
            end
         endcase
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff  <= CFG_W'(1);
         num_cols_ff  <= CFG_W'(1);
         in_valid_ff  <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         in_run_ff    <= 1'b0;
         open_ff      <= '0;
         nz_tally_ff  <= '0;
         run_tally_ff <= '0;
         cnt_ff       <= 2'd0;
      end else begin
         num_rows_ff  <= num_rows_in;
         num_cols_ff  <= num_cols_in;
         in_valid_ff  <= in_valid_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         in_run_ff    <= in_run_in;
         open_ff      <= open_in;
         nz_tally_ff  <= nz_tally_in;
         run_tally_ff <= run_tally_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      q0_ff      <= q0_in;
      q1_ff      <= q1_in;
   end

   // ---------------- assertions ----------------
   // the two-entry queue never overfills
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("output queue count out of range");

   // the second beat of an element is already queued behind the first
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second beat of an element missing");

   // matrix end only on a column end
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!q0_ff.payload.matrix_done || q0_ff.payload.column_done))
      else $error("matrix_done without column_done");

   // value beats never carry a zero element
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (q0_ff.kind == KIND_VALUE) |->
         ((q0_ff.payload.nonzero_value & ZERO_MASK) != '0))
      else $error("zero element sent as a value beat");

endmodule

### bench/czre_result_checker.sv
// czre_result_checker: watches the element, result and register ports of the
// zero-run encoder, predicts every result beat and compares it field by field
// depends on czre_pkg for field widths, codes and the result struct

module czre_result_checker #(
   parameter int unsigned MAX_ROWS    = czre_pkg::DEF_MAX_ROWS,
   parameter int unsigned MAX_COLUMNS = czre_pkg::DEF_MAX_COLUMNS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [czre_pkg::ELEM_W-1:0]     req_tdata,   // element_bits
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // column_index, nonzero_value, run_start, run_end, nonzero_count,
   // zero_run_count, column_done, matrix_done, zero pad
   input  logic [czre_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tuser,   // kind
   input  logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [czre_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [czre_pkg::CFG_W-1:0]      csr_wdata,
   output int                              error_count,
   output int                              outstanding,
   output int                              beats_checked,
   output int                              matrices_closed
);

   import czre_pkg::*;

   // encoder state as the stream sees it
   logic [CFG_W-1:0]       rows_cfg = CFG_W'(1);
   logic [CFG_W-1:0]       cols_cfg = CFG_W'(1);
   logic [RUN_START_W-1:0] row_pos;
   logic [COL_IDX_W-1:0]   col_pos;
   logic                   run_open;
   logic [RUN_START_W-1:0] run_from;
   logic [NZ_CNT_W-1:0]    nz_tally;
   logic [RUN_CNT_W-1:0]   run_tally;
   result_type             expected_beats[$];

   // 0 acts as 1, anything above the limit acts as the limit
   function automatic int unsigned effective_size(logic [CFG_W-1:0] raw, int unsigned limit);
      if (raw == '0) return 1;
      if (raw > limit) return limit;
      return 32'(raw);
   endfunction

   task automatic queue_beat(kind_type kind, logic [ELEM_W-1:0] value,
                             logic [RUN_START_W-1:0] first_row,
                             logic [RUN_END_W-1:0] end_row,
                             logic col_done, logic mat_done, logic last_beat);
      result_type beat;
      beat.kind                   = kind;
      beat.last                   = last_beat;
      beat.payload.column_index   = col_pos;
      beat.payload.nonzero_value  = value;
      beat.payload.run_start      = first_row;
      beat.payload.run_end        = end_row;
      beat.payload.nonzero_count  = nz_tally;
      beat.payload.zero_run_count = run_tally;
      beat.payload.column_done    = col_done;
      beat.payload.matrix_done    = mat_done;
      expected_beats.push_back(beat);
   endtask

   task automatic encode_element(logic [ELEM_W-1:0] bits);
      int unsigned rows;
      int unsigned cols;
      logic        last_row;
      logic        last_col;
      rows     = effective_size(rows_cfg, MAX_ROWS);
      cols     = effective_size(cols_cfg, MAX_COLUMNS);
      // a position at or past the size counts as the last one
      last_row = (int'(row_pos) + 1 >= rows);
      last_col = (int'(col_pos) + 1 >= cols);
      if ((bits & ZERO_MASK) == '0) begin
         if (!run_open) begin
            run_open = 1'b1;
            run_from = row_pos;
         end
         if (last_row) begin
            run_tally = run_tally + 1'b1;
            queue_beat(KIND_RUN, '0, run_from, {1'b0, row_pos} + 1'b1, 1'b1, last_col, 1'b1);
         end
      end else begin
         if (run_open) begin
            run_tally = run_tally + 1'b1;
            queue_beat(KIND_RUN, '0, run_from, {1'b0, row_pos}, 1'b0, 1'b0, 1'b0);
            run_open = 1'b0;
         end
         nz_tally = nz_tally + 1'b1;
         queue_beat(KIND_VALUE, bits, '0, '0, last_row, last_row && last_col, 1'b1);
      end
      if (last_row) begin
         row_pos   = '0;
         run_open  = 1'b0;
         run_from  = '0;
         nz_tally  = '0;
         run_tally = '0;
         col_pos   = last_col ? '0 : col_pos + 1'b1;
      end else begin
         row_pos = row_pos + 1'b1;
      end
   endtask

   function automatic int field_mismatch(string name, logic [ELEM_W-1:0] want,
                                         logic [ELEM_W-1:0] got);
      if (got === want) return 0;
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         rows_cfg  = CFG_W'(1);
         cols_cfg  = CFG_W'(1);
         row_pos   = '0;
         col_pos   = '0;
         run_open  = 1'b0;
         run_from  = '0;
         nz_tally  = '0;
         run_tally = '0;
         expected_beats.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_NUM_ROWS:    rows_cfg = csr_wdata;
               REG_NUM_COLUMNS: cols_cfg = csr_wdata;
               default: ;
            endcase
         end
         // compare before predicting: a beat never comes from this edge's element
         if (rsp_tvalid && rsp_tready) begin
            got.kind    = kind_type'(rsp_tuser);
            got.last    = rsp_tlast;
            got.payload = rsp_tdata[PAYLOAD_W-1:0];
            beats_checked = beats_checked + 1;
            if (got.payload.matrix_done === 1'b1) matrices_closed = matrices_closed + 1;
            if (expected_beats.size() == 0) begin
               $error("result beat with none expected: kind %0h column %0d",
                      got.kind, got.payload.column_index);
               error_count = error_count + 1;
            end else begin
               want = expected_beats.pop_front();
               error_count = error_count
                  + field_mismatch("kind", ELEM_W'(want.kind), ELEM_W'(got.kind))
                  + field_mismatch("last", ELEM_W'(want.last), ELEM_W'(got.last))
                  + field_mismatch("column_index", ELEM_W'(want.payload.column_index),
                                   ELEM_W'(got.payload.column_index))
                  + field_mismatch("nonzero_value", want.payload.nonzero_value,
                                   got.payload.nonzero_value)
                  + field_mismatch("run_start", ELEM_W'(want.payload.run_start),
                                   ELEM_W'(got.payload.run_start))
                  + field_mismatch("run_end", ELEM_W'(want.payload.run_end),
                                   ELEM_W'(got.payload.run_end))
                  + field_mismatch("nonzero_count", ELEM_W'(want.payload.nonzero_count),
                                   ELEM_W'(got.payload.nonzero_count))
                  + field_mismatch("zero_run_count", ELEM_W'(want.payload.zero_run_count),
                                   ELEM_W'(got.payload.zero_run_count))
                  + field_mismatch("column_done", ELEM_W'(want.payload.column_done),
                                   ELEM_W'(got.payload.column_done))
                  + field_mismatch("matrix_done", ELEM_W'(want.payload.matrix_done),
                                   ELEM_W'(got.payload.matrix_done))
                  + field_mismatch("pad", '0, ELEM_W'(rsp_tdata >> PAYLOAD_W));
            end
         end
         if (req_tvalid && req_tready) encode_element(req_tdata);
      end
      outstanding = expected_beats.size();
   end

endmodule

### bench/tb_column_zero_run_encoder.sv
// tb_column_zero_run_encoder: stimulus, register writes and verdict for the
// column zero-run encoder; depends on czre_pkg, column_zero_run_encoder and
// czre_result_checker, which does all prediction and comparison

module tb_column_zero_run_encoder;

   import czre_pkg::*;

   // time for the element register and output queue to empty; leaves some margin
   localparam int SETTLE_CYCLES   = 4;
   // cycles without any beat on either side before the run is declared hung
   localparam int WATCHDOG_LIMIT  = 2000;
   // receiver hold-off long enough to fill the block and back up the input
   localparam int LONG_STALL      = 80;
   localparam int RANDOM_ELEMENTS = 400;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ELEM_W-1:0]     req_tdata  = '0;      // element_bits
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // column_index, nonzero_value, run_start, run_end, nonzero_count,
   // zero_run_count, column_done, matrix_done, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;            // kind
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   reg_index_type         csr_index  = REG_NUM_ROWS;
   logic [CFG_W-1:0]      csr_wdata  = '0;

   // idle odds in percent, changed between traffic phases
   int send_idle_pct = 33;
   int recv_idle_pct = 57;
   // receiver hold-off, asked by the stimulus and counted down below
   int stall_request = 0;
   int stall_left    = 0;
   int quiet_cycles  = 0;
   int elements_sent = 0;

   int error_count;
   int outstanding;
   int beats_checked;
   int matrices_closed;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   column_zero_run_encoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   czre_result_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .outstanding     (outstanding),
      .beats_checked   (beats_checked),
      .matrices_closed (matrices_closed)
   );

   // receiver: random back-pressure, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (stall_request > 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: any beat on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // offer one element, with random gaps ahead of it; returns at the falling
   // edge after the beat with tvalid still high, so back-to-back beats stay
   // back to back
   task automatic put_element(input logic [ELEM_W-1:0] bits);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = bits;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      elements_sent = elements_sent + 1;
      @(negedge clock);
   endtask

   // stop sending, wait for every predicted beat, then let the pipe settle:
   // a trailing zero element yields no beat but may still be in flight
   task automatic drain();
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // sizes only change on an idle block; raw values, so 0 and >1024 go through
   task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      drain();
      csr_we    = 1'b1;
      csr_index = REG_NUM_ROWS;
      csr_wdata = rows;
      @(negedge clock);
      csr_index = REG_NUM_COLUMNS;
      csr_wdata = cols;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // zero of either sign with the given odds, otherwise a nonzero pattern
   function automatic logic [ELEM_W-1:0] random_element(input int zero_pct);
      logic [ELEM_W-1:0] bits;
      bits = '0;
      if ($urandom_range(99) < zero_pct) begin
         bits[ELEM_W-1] = 1'($urandom_range(1));
         return bits;
      end
      case ($urandom_range(3))
         0:       bits = 64'd1 << $urandom_range(62);            // lone mantissa/exponent bit
         1:       bits = {1'b0, 11'h7FF, 20'd0, 32'($urandom)};   // infinities and nans
         default: bits = {$urandom, $urandom};
      endcase
      bits[ELEM_W-1] = 1'($urandom_range(1));
      if ((bits & ZERO_MASK) == '0) bits[0] = 1'b1;
      return bits;
   endfunction

   initial begin
      int seg_rows;
      int seg_cols;
      int seg_len;
      int zero_pct;
      int random_count;

      // hold reset from time zero, then release it at a falling edge
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // ---- directed part ----
      // 4x2: both zero signs, subnormals, all-ones, zero run ending a column
      set_size(4, 2);
      put_element(64'h0000_0000_0000_0000);   // positive zero opens a run
      put_element(64'h8000_0000_0000_0000);   // negative zero extends it
      put_element(64'h0000_0000_0000_0001);   // smallest subnormal closes it
      put_element(64'hFFFF_FFFF_FFFF_FFFF);   // nonzero on the last row
      put_element(64'h8000_0000_0000_0001);
      put_element(64'h0000_0000_0000_0000);
      put_element(64'h8000_0000_0000_0000);
      put_element(64'h0000_0000_0000_0000);   // zero on last row of last column

      // shrink the rows while a column is half done: row 5 is past the new
      // size, so the next element closes the column
      set_size(8, 2);
      put_element(64'h7FF0_0000_0000_0000);   // +inf
      repeat (4) put_element(64'h0000_0000_0000_0000);
      set_size(3, 2);
      put_element(64'h8000_0000_0000_0000);

      // zero sizes act as 1; column 1 is already past the single column
      set_size(0, 0);
      put_element(64'hFFF0_0000_0000_0000);   // -inf closes column and matrix
      put_element(64'h8000_0000_0000_0000);
      put_element(64'h0010_0000_0000_0000);   // smallest normal

      // a clean 2x3 matrix with runs at the top, bottom and a whole column
      set_size(2, 3);
      put_element(64'h3FF0_0000_0000_0000);
      put_element(64'h0000_0000_0000_0000);
      put_element(64'h8000_0000_0000_0000);
      put_element(random_element(0));
      put_element(64'h0000_0000_0000_0000);
      put_element(64'h0000_0000_0000_0000);

      // ---- random part: three idle mixes ----
      random_count = 0;
      while (random_count < RANDOM_ELEMENTS) begin
         if (random_count >= (2 * RANDOM_ELEMENTS) / 3) begin
            if (send_idle_pct != 0 || recv_idle_pct != 0) begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // hold the receiver off while elements keep coming, so the
               // output queue fills and the input backs up
               stall_request = LONG_STALL;
               repeat (30) put_element(random_element(20));
               random_count += 30;
            end
         end else if (random_count >= RANDOM_ELEMENTS / 3) begin
            send_idle_pct = 57;
            recv_idle_pct = 33;
         end

         case ($urandom_range(9))
            0:       seg_rows = 0;
            1:       seg_rows = $urandom_range(13, 64);
            default: seg_rows = $urandom_range(1, 12);
         endcase
         seg_cols = $urandom_range(0, 5);
         zero_pct = $urandom_range(10, 90);
         // mostly one matrix worth, sometimes cut short or running on;
         // the next resize then lands in the middle of a matrix
         seg_len = (seg_rows == 0 ? 1 : seg_rows) * (seg_cols == 0 ? 1 : seg_cols);
         if ($urandom_range(3) == 0) seg_len = $urandom_range(1, 2 * seg_len);
         // short segments, so every idle mix gets its share
         if (seg_len > RANDOM_ELEMENTS / 6) seg_len = RANDOM_ELEMENTS / 6;
         set_size(CFG_W'(seg_rows), CFG_W'(seg_cols));
         repeat (seg_len) put_element(random_element(zero_pct));
         random_count += seg_len;
      end

      // ---- largest sizes ----
      // 1x1 closes whatever matrix is open, so the next one starts clean
      set_size(1, 1);
      put_element(random_element(50));

      // one full-height column; the written value is above the maximum
      // alternating values and single zeros give the most runs a column holds
      set_size(11'h7FF, 1);
      for (int row = 0; row < DEF_MAX_ROWS; row++)
         put_element(row % 2 == 0 ? random_element(0) : 64'h0000_0000_0000_0000);

      // a column count above the maximum acts as the maximum; a stretch of
      // one-row columns from the start of that wide matrix
      set_size(1, 11'h7FF);
      repeat (64) put_element(random_element(50));

      drain();

      $display("run covered %0d elements, %0d result beats, %0d matrix ends",
               elements_sent, beats_checked, matrices_closed);
      $display("sizes 1x1 to 1024x1, clamped and zero sizes, resizes mid-matrix");
      if (error_count == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### files.f
hdl/czre_pkg.sv
hdl/column_zero_run_encoder.sv
bench/czre_result_checker.sv
bench/tb_column_zero_run_encoder.sv
